// File: src/assert_macros.svh
// Assertion macros used by the checker module.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define KMT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kmt check failed");

// Next-cycle implication, disabled during reset.
`define KMT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kmt check failed");

`endif

// File: src/kmt_pkg.sv
// Package for the keyed minimum tracker table: sizes, operation codes and
// the token that travels along the cell chain. No dependencies.
package kmt_pkg;

    localparam int ENTRIES   = 16;
    localparam int THREAD_W  = 16;
    localparam int JOB_W     = 64;
    localparam int FILE_W    = 64;
    localparam int OCC_W     = 5;
    localparam int CNT_RAW_W = $clog2(ENTRIES + 1);
    localparam int CNT_W     = (CNT_RAW_W > OCC_W) ? CNT_RAW_W : OCC_W;

    localparam logic [FILE_W-1:0] FILE_ALL_ONES = {FILE_W{1'b1}};

    typedef enum logic {
        FUNC_INSERT = 1'b0,
        FUNC_REMOVE = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_SWEEP
    } t_state;

    typedef struct packed {
        logic              active;
        logic              placed;
        logic [FILE_W-1:0] least;
        logic [CNT_W-1:0]  count;
    } t_tok;

endpackage

// File: src/kmt_cell.sv
// One table slot of the tracker chain: holds a key and file number, applies
// the passing operation token and forwards it. Depends on kmt_pkg.
module kmt_cell
    import kmt_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_func               i_func,
    input  logic                i_hit,
    input  logic [THREAD_W-1:0] i_thread,
    input  logic [JOB_W-1:0]    i_job,
    input  logic [FILE_W-1:0]   i_file,
    input  t_tok                i_tok,
    output t_tok                o_tok,
    output logic                o_match
);

    logic                r_valid;
    logic [THREAD_W-1:0] r_thread;
    logic [JOB_W-1:0]    r_job;
    logic [FILE_W-1:0]   r_file;
    t_tok                r_tok;

    logic                n_valid;
    t_tok                n_tok;
    logic                write_here;
    logic                clear_here;
    logic [FILE_W-1:0]   file_eff;

    assign o_match = r_valid && (r_thread == i_thread) && (r_job == i_job);

    always_comb begin
        write_here = i_tok.active && (i_func == FUNC_INSERT) && !i_hit
                     && !i_tok.placed && !r_valid;
        clear_here = i_tok.active && (i_func == FUNC_REMOVE) && o_match;
        if (write_here) begin
            n_valid = 1'b1;
        end else if (clear_here) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
        file_eff     = write_here ? i_file : r_file;
        n_tok.active = i_tok.active;
        n_tok.placed = i_tok.placed | write_here;
        n_tok.count  = i_tok.count + CNT_W'(n_valid);
        n_tok.least  = (n_valid && (file_eff < i_tok.least)) ? file_eff : i_tok.least;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tok   <= '0;
        end else begin
            r_valid <= n_valid;
            r_tok   <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (write_here) begin
            r_thread <= i_thread;
            r_job    <= i_job;
            r_file   <= i_file;
        end
    end

    assign o_tok = r_tok;

endmodule

// File: src/keyed_min_tracker_table.sv
// Top level of the keyed minimum tracker table: command port, sequencer and
// the chain of kmt_cell slots. Depends on kmt_pkg and kmt_cell.
//
// One item at a time: an item is taken when start is high and busy is low,
// and its single result is on o_valid once the token leaves the last slot;
// busy falls as that result cycle ends, so the next item can be taken in
// the cycle after the result, and a new item is not taken before the last
// one is through. The match state compares the key against every slot at once;
// the operation token then walks the slot chain one cell per cycle, inserting,
// removing, counting and tracking the smallest file number as it goes. The
// result is shown for exactly one cycle and cannot be held off.
module keyed_min_tracker_table
    import kmt_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                i_func,
    input  logic [THREAD_W-1:0] i_thread_num,
    input  logic [JOB_W-1:0]    i_job_num,
    input  logic [FILE_W-1:0]   i_file_num,
    output logic                o_valid,
    output logic [FILE_W-1:0]   o_smallest_file,
    output logic                o_key_hit,
    output logic                o_table_full,
    output logic [OCC_W-1:0]    o_occupancy
);

    t_state              r_state;
    t_state              n_state;
    t_func               r_func;
    logic [THREAD_W-1:0] r_thread;
    logic [JOB_W-1:0]    r_job;
    logic [FILE_W-1:0]   r_file;
    logic                r_hit;
    logic                r_launch;
    logic                accept;
    logic                leave_match;
    logic                done;
    logic [ENTRIES-1:0]  match;
    t_tok                tok [ENTRIES+1];

    assign accept = start && !busy;
    assign done   = tok[ENTRIES].active;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (start) n_state = ST_MATCH;
            ST_MATCH: n_state = ST_SWEEP;
            ST_SWEEP: if (done) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        busy        = 1'b1;
        leave_match = 1'b0;
        unique case (r_state)
            ST_IDLE:  busy = 1'b0;
            ST_MATCH: leave_match = 1'b1;
            ST_SWEEP: busy = 1'b1;
            default:  busy = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_launch <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_launch <= leave_match;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func   <= t_func'(i_func);
            r_thread <= i_thread_num;
            r_job    <= i_job_num;
            r_file   <= i_file_num;
        end
        if (leave_match) begin
            r_hit <= |match;
        end
    end

    assign tok[0] = {r_launch, 1'b0, FILE_ALL_ONES, CNT_W'(0)};

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        kmt_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_func   (r_func),
            .i_hit    (r_hit),
            .i_thread (r_thread),
            .i_job    (r_job),
            .i_file   (r_file),
            .i_tok    (tok[g]),
            .o_tok    (tok[g+1]),
            .o_match  (match[g])
        );
    end

    assign o_valid         = done;
    assign o_smallest_file = tok[ENTRIES].least;
    assign o_key_hit       = r_hit;
    assign o_table_full    = (r_func == FUNC_INSERT) && !r_hit && !tok[ENTRIES].placed;
    assign o_occupancy     = tok[ENTRIES].count[OCC_W-1:0];

endmodule

// File: src/kmt_checker.sv
// Port-level checks for keyed_min_tracker_table, bound to the top level.
// Depends on kmt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module kmt_checker
    import kmt_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic             o_valid,
    input logic             o_key_hit,
    input logic             o_table_full,
    input logic [OCC_W-1:0] o_occupancy
);

    `KMT_ASSERT_NOW(a_valid_busy, i_clk, i_rst_n, o_valid, busy)
    `KMT_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `KMT_ASSERT_NEXT(a_one_result, i_clk, i_rst_n, o_valid, !o_valid && !busy)
    `KMT_ASSERT_NOW(a_full_no_hit, i_clk, i_rst_n, o_valid && o_table_full, !o_key_hit)
    `KMT_ASSERT_NOW(a_full_occ, i_clk, i_rst_n, o_valid && o_table_full, o_occupancy == OCC_W'(ENTRIES))

endmodule

bind keyed_min_tracker_table kmt_checker u_kmt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_valid      (o_valid),
    .o_key_hit    (o_key_hit),
    .o_table_full (o_table_full),
    .o_occupancy  (o_occupancy)
);

// File: bench/tb_top.sv
// Testbench for keyed_min_tracker_table: a directed table of insert and remove items,
// then random items. Typed rows are checked against their own results, the rest against
// an in-bench model of the slot table. Depends on kmt_pkg and keyed_min_tracker_table.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import kmt_pkg::*;

    localparam int N_RANDOM = 2000;

    typedef struct {
        t_func               func;
        logic [THREAD_W-1:0] thread;
        logic [JOB_W-1:0]    job;
        logic [FILE_W-1:0]   file;
    } t_item;

    typedef struct packed {
        logic [FILE_W-1:0] smallest;
        logic              hit;
        logic              full;
        logic [OCC_W-1:0]  occ;
    } t_result;

    typedef struct {
        t_item   item;
        int      reps;
        bit      typed;
        t_result res;
    } t_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic                i_func;
    logic [THREAD_W-1:0] i_thread_num;
    logic [JOB_W-1:0]    i_job_num;
    logic [FILE_W-1:0]   i_file_num;
    logic                o_valid;
    logic [FILE_W-1:0]   o_smallest_file;
    logic                o_key_hit;
    logic                o_table_full;
    logic [OCC_W-1:0]    o_occupancy;

    bit                  tbl_valid [ENTRIES];
    logic [THREAD_W-1:0] tbl_thread [ENTRIES];
    logic [JOB_W-1:0]    tbl_job [ENTRIES];
    logic [FILE_W-1:0]   tbl_file [ENTRIES];

    t_result pending_results [$];
    int      n_errors = 0;

    keyed_min_tracker_table DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_func          (i_func),
        .i_thread_num    (i_thread_num),
        .i_job_num       (i_job_num),
        .i_file_num      (i_file_num),
        .o_valid         (o_valid),
        .o_smallest_file (o_smallest_file),
        .o_key_hit       (o_key_hit),
        .o_table_full    (o_table_full),
        .o_occupancy     (o_occupancy)
    );

    always #6 i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        n_errors++;
        $display("tb_top: mismatch at %0t: %s", $time, what);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Apply one item to the table and return the result it produces.
    function automatic t_result min_table_step(t_item it);
        t_result     r;
        int          at;
        int          fr;
        int          i;
        int unsigned cnt;
        at = -1;
        fr = -1;
        for (i = ENTRIES - 1; i >= 0; i--) begin
            if (tbl_valid[i] && tbl_thread[i] == it.thread && tbl_job[i] == it.job) at = i;
            if (!tbl_valid[i]) fr = i;
        end
        r = '0;
        r.smallest = FILE_ALL_ONES;
        if (it.func == FUNC_INSERT) begin
            if (at >= 0) begin
                r.hit = 1'b1;
            end else if (fr < 0) begin
                r.full = 1'b1;
            end else begin
                tbl_valid[fr]  = 1'b1;
                tbl_thread[fr] = it.thread;
                tbl_job[fr]    = it.job;
                tbl_file[fr]   = it.file;
            end
        end else if (at >= 0) begin
            r.hit = 1'b1;
            tbl_valid[at] = 1'b0;
        end
        cnt = 0;
        for (i = 0; i < ENTRIES; i++) begin
            if (tbl_valid[i]) begin
                cnt++;
                if (tbl_file[i] < r.smallest) r.smallest = tbl_file[i];
            end
        end
        r.occ = cnt[OCC_W-1:0];
        return r;
    endfunction

    // Random item: keys mostly from a small pool so that they collide, removes mostly of live keys.
    function automatic t_item pick_item(int ins_pct);
        t_item it;
        int    live [$];
        int    pick;
        int    r;
        foreach (tbl_valid[i]) begin
            if (tbl_valid[i]) live.push_back(i);
        end
        it.func = ($urandom_range(99) < ins_pct) ? FUNC_INSERT : FUNC_REMOVE;
        case ($urandom_range(2))
            0: it.thread = THREAD_W'($urandom_range(3));
            1: it.thread = '1;
            default: it.thread = THREAD_W'($urandom);
        endcase
        case ($urandom_range(2))
            0: it.job = JOB_W'($urandom_range(7));
            1: it.job = '1;
            default: it.job = rand64();
        endcase
        r = $urandom_range(99);
        if (live.size() > 0 && ((it.func == FUNC_REMOVE && r < 75) ||
                                (it.func == FUNC_INSERT && r < 15))) begin
            pick = live[$urandom_range(live.size() - 1)];
            it.thread = tbl_thread[pick];
            it.job = tbl_job[pick];
        end
        case ($urandom_range(9))
            0: it.file = '1;
            1: it.file = '0;
            2, 3, 4: it.file = FILE_W'($urandom_range(31));
            default: it.file = rand64();
        endcase
        return it;
    endfunction

    function automatic t_row dir_row(t_func f, logic [15:0] th, logic [63:0] jb,
                                     logic [63:0] fl, int reps, bit typed,
                                     logic [63:0] sm, logic hit, logic full, int occ);
        t_row rw;
        rw.item.func   = f;
        rw.item.thread = th;
        rw.item.job    = jb;
        rw.item.file   = fl;
        rw.reps        = reps;
        rw.typed       = typed;
        rw.res.smallest = sm;
        rw.res.hit     = hit;
        rw.res.full    = full;
        rw.res.occ     = occ[OCC_W-1:0];
        return rw;
    endfunction

    // Enter and leave at a falling edge; hold start high across items when gap is zero and after_busy is clear.
    task automatic send_item(t_item it, bit typed, t_result typed_res, int gap,
                             bit after_busy);
        t_result r;
        if (after_busy) begin
            start <= 1'b0;
            do @(negedge i_clk); while (busy);
            repeat (gap) @(negedge i_clk);
        end else if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start        <= 1'b1;
        i_func       <= it.func;
        i_thread_num <= it.thread;
        i_job_num    <= it.job;
        i_file_num   <= it.file;
        do @(posedge i_clk); while (busy);
        r = min_table_step(it);
        pending_results.push_back(typed ? typed_res : r);
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no item pending");
            end else begin
                want = pending_results.pop_front();
                if (o_smallest_file !== want.smallest)
                    report_mismatch($sformatf("smallest_file %h, want %h",
                                              o_smallest_file, want.smallest));
                if (o_key_hit !== want.hit)
                    report_mismatch($sformatf("key_hit %b, want %b", o_key_hit, want.hit));
                if (o_table_full !== want.full)
                    report_mismatch($sformatf("table_full %b, want %b",
                                              o_table_full, want.full));
                if (o_occupancy !== want.occ)
                    report_mismatch($sformatf("occupancy %0d, want %0d",
                                              o_occupancy, want.occ));
            end
        end
    end

    initial begin
        t_row        directed [$];
        t_item       it;
        int          ins_pct;
        bit          calm;
        logic [63:0] ones;
        logic [63:0] hi;
        ones = '1;
        hi   = 64'h8000_0000_0000_0000;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_func       = FUNC_INSERT;
        i_thread_num = '0;
        i_job_num    = '0;
        i_file_num   = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        directed = '{
            dir_row(FUNC_REMOVE, 16'h0, 64'h0, ones, 1, 1, ones, 0, 0, 0),
            dir_row(FUNC_INSERT, 16'h0, 64'h0, 64'h0, 1, 1, 64'h0, 0, 0, 1),
            dir_row(FUNC_INSERT, 16'hFFFF, ones, ones, 1, 1, 64'h0, 0, 0, 2),
            dir_row(FUNC_INSERT, 16'h0, 64'h0, 64'h5, 1, 1, 64'h0, 1, 0, 2),
            dir_row(FUNC_REMOVE, 16'h0, 64'h0, 64'h0, 1, 1, ones, 1, 0, 1),
            dir_row(FUNC_REMOVE, 16'hFFFF, ones, 64'h0, 1, 1, ones, 1, 0, 0),
            dir_row(FUNC_REMOVE, 16'hFFFF, ones, 64'h0, 1, 1, ones, 0, 0, 0),
            dir_row(FUNC_INSERT, 16'h7, 64'd1000, hi, ENTRIES, 0, '0, 0, 0, 0),
            dir_row(FUNC_INSERT, 16'h7, 64'd2000, 64'h0, 1, 1, hi, 0, 1, ENTRIES),
            dir_row(FUNC_INSERT, 16'h7, 64'd1005, 64'h3, 1, 1, hi, 1, 0, ENTRIES),
            dir_row(FUNC_REMOVE, 16'h7, 64'd1000, ones, 1, 1, hi + 1, 1, 0, ENTRIES - 1),
            dir_row(FUNC_INSERT, 16'h7, 64'd2000, 64'h1, 1, 1, 64'h1, 0, 0, ENTRIES),
            dir_row(FUNC_REMOVE, 16'h7, 64'd2000, 64'h0, 1, 1, hi + 1, 1, 0, ENTRIES - 1),
            dir_row(FUNC_REMOVE, 16'h3, 64'd1001, 64'h0, 1, 0, '0, 0, 0, 0),
            dir_row(FUNC_REMOVE, 16'h7, 64'd999, 64'h0, 1, 0, '0, 0, 0, 0)
        };

        foreach (directed[n]) begin
            for (int k = 0; k < directed[n].reps; k++) begin
                it = directed[n].item;
                it.job += JOB_W'(k);
                it.file += FILE_W'(k);
                send_item(it, directed[n].typed, directed[n].res, $urandom_range(8),
                          1'($urandom_range(1)));
            end
        end

        ins_pct = 50;
        calm = 1'b0;
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 64 == 0) begin
                case ($urandom_range(3))
                    0: ins_pct = 20;
                    1: ins_pct = 50;
                    2: ins_pct = 80;
                    default: ins_pct = 95;
                endcase
                calm = ($urandom_range(3) == 0);
            end
            send_item(pick_item(ins_pct), 1'b0, '0, calm ? 0 : $urandom_range(8),
                      calm ? 1'b0 : 1'($urandom_range(1)));
        end
        start <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (ENTRIES + 4) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb_top: errors");
        $finish;
    end

endmodule
